### design/tbm_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tbm_pkg
// Widths, types and stage counts shared by the tetrahedron matrix core.
// ---------------------------------------------------------------------------
package tbm_pkg;

   localparam int CW     = 32;             // coordinate width
   localparam int FB     = 16;             // fraction bits
   localparam int NV     = 12;             // input coordinates
   localparam int NE     = 9;              // matrix elements
   localparam int EW     = CW + 1;         // edge vector component
   localparam int PW     = 2 * EW;         // cofactor product
   localparam int CFW    = PW + 1;         // cofactor
   localparam int SPLIT  = CFW / 2;        // low part of a split cofactor
   localparam int HW     = CFW - SPLIT;    // high part of a split cofactor
   localparam int PPW    = EW + SPLIT + 1; // determinant partial product
   localparam int DW     = EW + CFW + 2;   // determinant
   localparam int DDW    = DW + 1;         // divisor, twice the determinant
   localparam int NW     = CFW + 2 * FB + 2;
   localparam int RW     = (NW > DDW + CW) ? NW : DDW + CW;
   localparam int NCOF   = 3;              // cofactor stages
   localparam int NDET   = 5;              // determinant and setup stages
   localparam int NST    = NCOF + NDET + CW + 1;
   localparam int IN_DW  = ((NV * CW + 7) / 8) * 8;
   localparam int OUT_DW = ((NE * CW + 7) / 8) * 8;

   typedef logic [NV-1:0][CW-1:0]   vtx_type;
   typedef logic [2:0][EW-1:0]      edge_row_type;
   typedef logic [NE-1:0][CFW-1:0]  cof_vec_type;
   typedef logic [RW-1:0]           rem_type;
   typedef logic [DDW-1:0]          den_type;
   typedef logic [CW-1:0]           quo_type;
   typedef logic [NE-1:0][CW-1:0]   res_vec_type;

   typedef struct packed {
      logic ovf;
      logic neg;
   } lane_flag_type;

   typedef lane_flag_type [NE-1:0] lane_flags_type;

endpackage

### design/tetrahedron_barycentric_matrix_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tetrahedron_barycentric_matrix_core
// Inverse of the tetrahedron edge matrix for barycentric coordinates.
// ---------------------------------------------------------------------------
// Takes one tetrahedron (four corners, signed Q16.16) per cycle and returns
// the inverse of the matrix with rows a-d, b-d, c-d, each element rounded to
// nearest (ties away from zero) and clamped to Q16.16. The pipeline holds
// three cofactor stages, five determinant and setup stages, one restoring
// divider stage per quotient bit and one output stage.
// Throughput is one item per clock; a stalled result holds only the stages
// that are full. tuser bit 0 flags a zero determinant (all elements zero),
// bit 1 flags that at least one element was clamped.
module tetrahedron_barycentric_matrix_core import tbm_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   // vertex_a_x, vertex_a_y, vertex_a_z, vertex_b_x, vertex_b_y, vertex_b_z,
   // vertex_c_x, vertex_c_y, vertex_c_z, vertex_d_x, vertex_d_y, vertex_d_z
   input  logic [IN_DW-1:0]   req_tdata,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   // inv_r0c0, inv_r0c1, inv_r0c2, inv_r1c0, inv_r1c1, inv_r1c2,
   // inv_r2c0, inv_r2c1, inv_r2c2
   output logic [OUT_DW-1:0]  rsp_tdata,
   // singular, saturated
   output logic [1:0]         rsp_tuser
);

   localparam int DIV0 = NCOF + NDET;

   logic [NST-1:0]  valid_ff;
   logic [NST-1:0]  stage_en;

   vtx_type         vtx;
   cof_vec_type     adj;
   edge_row_type    mrow;
   rem_type         num [NE];
   den_type         den;
   lane_flags_type  det_flags, div_flags;
   logic            det_zero, div_zero;
   quo_type         quo [NE];

   res_vec_type     res_in, res_ff;
   logic            sing_in, sing_ff, sat_in, sat_ff;

   always_comb begin
      stage_en[NST-1] = !valid_ff[NST-1] || rsp_tready;
      for (int k = NST - 2; k >= 0; k--) begin
         stage_en[k] = !valid_ff[k] || stage_en[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (stage_en[0]) begin
            valid_ff[0] <= req_tvalid;
         end
         for (int k = 1; k < NST; k++) begin
            if (stage_en[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   always_comb begin
      for (int k = 0; k < NV; k++) begin
         vtx[k] = req_tdata[k*CW +: CW];
      end
   end

   tbm_cofactor u_cofactor (
      .clock    (clock),
      .stage_en (stage_en[NCOF-1:0]),
      .vtx      (vtx),
      .adj      (adj),
      .mrow     (mrow)
   );

   tbm_det u_det (
      .clock    (clock),
      .stage_en (stage_en[NCOF +: NDET]),
      .adj      (adj),
      .mrow     (mrow),
      .num      (num),
      .den      (den),
      .flags    (det_flags),
      .zero     (det_zero)
   );

   tbm_div u_div (
      .clock     (clock),
      .stage_en  (stage_en[DIV0 +: CW]),
      .num       (num),
      .den       (den),
      .flags_in  (det_flags),
      .zero_in   (det_zero),
      .quo       (quo),
      .flags_out (div_flags),
      .zero_out  (div_zero)
   );

   always_comb begin
      quo_type lim, mag;
      logic    sat;
      sat_in = 1'b0;
      for (int l = 0; l < NE; l++) begin
         lim = div_flags[l].neg ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
         sat = div_flags[l].ovf || (quo[l] > lim);
         mag = sat ? lim : quo[l];
         res_in[l] = div_flags[l].neg ? (~mag + 1'b1) : mag;
         sat_in = sat_in | sat;
      end
      sing_in = div_zero;
      if (div_zero) begin
         res_in = '0;
         sat_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[NST-1]) begin
         res_ff  <= res_in;
         sing_ff <= sing_in;
         sat_ff  <= sat_in;
      end
   end

   assign req_tready = stage_en[0];
   assign rsp_tvalid = valid_ff[NST-1];
   assign rsp_tdata  = OUT_DW'(res_ff);
   assign rsp_tuser  = {sat_ff, sing_ff};

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> valid_ff[0])
      else $error("input stalled with empty first stage");

   a_stalled_stage_holds: assert property (@(posedge clock) disable iff (reset)
      valid_ff[NCOF] && !stage_en[NCOF] |=> valid_ff[NCOF])
      else $error("stalled item dropped");

   a_singular_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> !rsp_tuser[1] && (res_ff == '0))
      else $error("singular result not zeroed");

endmodule

### design/tbm_cofactor.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tbm_cofactor
// Edge vectors, cofactor products and the adjugate in three stages.
// ---------------------------------------------------------------------------
module tbm_cofactor import tbm_pkg::*; (
   input  logic              clock,
   input  logic [NCOF-1:0]   stage_en,
   input  vtx_type           vtx,
   output cof_vec_type       adj,
   output edge_row_type      mrow
);

   logic [NE-1:0][EW-1:0]        edge_in, edge_ff;
   logic [NE-1:0][1:0][PW-1:0]   prod_in, prod_ff;
   cof_vec_type                  adj_in, adj_ff;
   edge_row_type                 mrow2_ff, mrow3_ff;

   always_comb begin
      for (int k = 0; k < NE; k++) begin
         edge_in[k] = $signed(vtx[k]) - $signed(vtx[NE + (k % 3)]);
      end
   end

   always_comb begin
      int i, j, i1, i2, j1, j2;
      for (int k = 0; k < NE; k++) begin
         i  = k / 3;
         j  = k % 3;
         i1 = (i + 1) % 3;
         i2 = (i + 2) % 3;
         j1 = (j + 1) % 3;
         j2 = (j + 2) % 3;
         prod_in[k][0] = $signed(edge_ff[j1*3 + i1]) * $signed(edge_ff[j2*3 + i2]);
         prod_in[k][1] = $signed(edge_ff[j1*3 + i2]) * $signed(edge_ff[j2*3 + i1]);
      end
   end

   always_comb begin
      for (int k = 0; k < NE; k++) begin
         adj_in[k] = $signed(prod_ff[k][0]) - $signed(prod_ff[k][1]);
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         edge_ff <= edge_in;
      end
      if (stage_en[1]) begin
         prod_ff  <= prod_in;
         mrow2_ff <= edge_ff[2:0];
      end
      if (stage_en[2]) begin
         adj_ff   <= adj_in;
         mrow3_ff <= mrow2_ff;
      end
   end

   assign adj  = adj_ff;
   assign mrow = mrow3_ff;

endmodule

### design/tbm_det.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tbm_det
// Determinant by split partial products, then magnitudes, dividends and
// the overflow check that feed the divider.
// ---------------------------------------------------------------------------
module tbm_det import tbm_pkg::*; (
   input  logic              clock,
   input  logic [NDET-1:0]   stage_en,
   input  cof_vec_type       adj,
   input  edge_row_type      mrow,
   output rem_type           num [NE],
   output den_type           den,
   output lane_flags_type    flags,
   output logic              zero
);

   logic [2:0][PPW-1:0]  plo_in, plo_ff, phi_in, phi_ff;
   logic [2:0][DW-1:0]   term_in, term_ff;
   logic [DW-1:0]        det_in, det_ff;
   cof_vec_type          adj4_ff, adj5_ff, adj6_ff;

   rem_type              num_in [NE];
   rem_type              num7_ff [NE];
   rem_type              num8_ff [NE];
   den_type              den_in, den7_ff, den8_ff;
   logic [NE-1:0]        neg_in, neg7_ff;
   lane_flags_type       flag8_ff;
   logic                 zero_in, zero7_ff, zero8_ff;

   always_comb begin
      logic signed [SPLIT:0]  lo;
      logic signed [HW-1:0]   hi;
      for (int i = 0; i < 3; i++) begin
         lo        = {1'b0, adj[i*3][SPLIT-1:0]};
         hi        = adj[i*3][CFW-1:SPLIT];
         plo_in[i] = $signed(mrow[i]) * lo;
         phi_in[i] = $signed(mrow[i]) * hi;
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         term_in[i] = ($signed(phi_ff[i]) <<< SPLIT) + $signed(plo_ff[i]);
      end
   end

   assign det_in = $signed(term_ff[0]) + $signed(term_ff[1]) + $signed(term_ff[2]);

   always_comb begin
      logic           dneg, aneg;
      logic [DW-1:0]  dabs;
      logic [CFW-1:0] aabs;
      dneg    = det_ff[DW-1];
      dabs    = dneg ? (~det_ff + 1'b1) : det_ff;
      zero_in = (det_ff == '0);
      den_in  = {dabs, 1'b0};
      for (int k = 0; k < NE; k++) begin
         aneg      = adj6_ff[k][CFW-1];
         aabs      = aneg ? (~adj6_ff[k] + 1'b1) : adj6_ff[k];
         neg_in[k] = aneg ^ dneg;
         num_in[k] = (RW'(aabs) << (2 * FB + 1)) + RW'(dabs);
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         plo_ff  <= plo_in;
         phi_ff  <= phi_in;
         adj4_ff <= adj;
      end
      if (stage_en[1]) begin
         term_ff <= term_in;
         adj5_ff <= adj4_ff;
      end
      if (stage_en[2]) begin
         det_ff  <= det_in;
         adj6_ff <= adj5_ff;
      end
      if (stage_en[3]) begin
         num7_ff  <= num_in;
         den7_ff  <= den_in;
         neg7_ff  <= neg_in;
         zero7_ff <= zero_in;
      end
      if (stage_en[4]) begin
         for (int k = 0; k < NE; k++) begin
            num8_ff[k]      <= num7_ff[k];
            flag8_ff[k].ovf <= num7_ff[k] >= (RW'(den7_ff) << CW);
            flag8_ff[k].neg <= neg7_ff[k];
         end
         den8_ff  <= den7_ff;
         zero8_ff <= zero7_ff;
      end
   end

   assign num   = num8_ff;
   assign den   = den8_ff;
   assign flags = flag8_ff;
   assign zero  = zero8_ff;

endmodule

### design/tbm_div.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tbm_div
// Nine-lane restoring divider, one quotient bit per stage, shared divisor.
// ---------------------------------------------------------------------------
module tbm_div import tbm_pkg::*; (
   input  logic              clock,
   input  logic [CW-1:0]     stage_en,
   input  rem_type           num [NE],
   input  den_type           den,
   input  lane_flags_type    flags_in,
   input  logic              zero_in,
   output quo_type           quo [NE],
   output lane_flags_type    flags_out,
   output logic              zero_out
);

   rem_type         rem_ff  [CW][NE];
   quo_type         quo_ff  [CW][NE];
   den_type         den_ff  [CW];
   lane_flags_type  flag_ff [CW];
   logic            zero_ff [CW];

   for (genvar s = 0; s < CW; s++) begin : g_stage
      localparam int B = CW - 1 - s;

      rem_type         rem_src [NE];
      quo_type         quo_src [NE];
      den_type         den_src;
      lane_flags_type  flag_src;
      logic            zero_src;
      rem_type         rem_in [NE];
      quo_type         quo_in [NE];

      if (s == 0) begin : g_head
         always_comb begin
            for (int l = 0; l < NE; l++) begin
               rem_src[l] = num[l];
               quo_src[l] = '0;
            end
            den_src  = den;
            flag_src = flags_in;
            zero_src = zero_in;
         end
      end else begin : g_body
         always_comb begin
            for (int l = 0; l < NE; l++) begin
               rem_src[l] = rem_ff[s-1][l];
               quo_src[l] = quo_ff[s-1][l];
            end
            den_src  = den_ff[s-1];
            flag_src = flag_ff[s-1];
            zero_src = zero_ff[s-1];
         end
      end

      always_comb begin
         logic [RW:0] trial;
         for (int l = 0; l < NE; l++) begin
            trial     = {1'b0, rem_src[l]} - {1'b0, (RW'(den_src) << B)};
            rem_in[l] = trial[RW] ? rem_src[l] : trial[RW-1:0];
            quo_in[l] = trial[RW] ? quo_src[l] : (quo_src[l] | (CW'(1) << B));
         end
      end

      always_ff @(posedge clock) begin
         if (stage_en[s]) begin
            for (int l = 0; l < NE; l++) begin
               rem_ff[s][l] <= rem_in[l];
               quo_ff[s][l] <= quo_in[l];
            end
            den_ff[s]  <= den_src;
            flag_ff[s] <= flag_src;
            zero_ff[s] <= zero_src;
         end
      end
   end

   assign quo       = quo_ff[CW-1];
   assign flags_out = flag_ff[CW-1];
   assign zero_out  = zero_ff[CW-1];

endmodule
